// File: design/prim_mst_pkg.sv
// ----------------------------------------------------------------------------
// prim_mst_pkg
// Shared types and constants of the minimum spanning tree engine.
// ----------------------------------------------------------------------------
package prim_mst_pkg;

  localparam int MAX_NODES_DEF     = 64;
  localparam int WEIGHT_BITS_DEF   = 16;
  localparam int NODE_FIELD_BITS   = 6;
  localparam int WEIGHT_FIELD_BITS = 16;
  localparam int COUNT_BITS        = 7;
  localparam int S_DATA_BITS       = 32;
  localparam int M_DATA_BITS       = 32;

  localparam logic [COUNT_BITS-1:0] COUNT_RESET = 7'd32;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_RUN   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_FROM,
    ST_WGT,
    ST_EMIT,
    ST_UPDATE
  } state_t;

endpackage

// File: design/prim_minimum_spanning_tree.sv
// ----------------------------------------------------------------------------
// prim_minimum_spanning_tree
// Prim's minimum spanning tree over an adjacency matrix held in memory.
// ----------------------------------------------------------------------------
// A write item (tuser 0) stores one matrix weight when its row and column lie
// below MAX_NODES. A run item (tuser 1) builds the tree from node 0 over the
// first n nodes (n clamped to MAX_NODES; a run with n below 2 does nothing)
// and holds the input side until its last edge is handed to the output register.
// An edge waits in ST_EMIT while the output register is full. The pace of a run
// is set by the distance memory's single read port: every step scans nodes 1 to
// n-1 once for the closest one outside the tree and, but for the last step, then
// relaxes them once against the new member, one node per cycle through one shared comparator.
module prim_minimum_spanning_tree #(
  parameter int MAX_NODES   = prim_mst_pkg::MAX_NODES_DEF,
  parameter int WEIGHT_BITS = prim_mst_pkg::WEIGHT_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [prim_mst_pkg::COUNT_BITS-1:0]   cfg_data,   // node_count
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [prim_mst_pkg::S_DATA_BITS-1:0]  s_tdata,    // row, col, weight
  input  logic                                  s_tuser,    // mode
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [prim_mst_pkg::M_DATA_BITS-1:0]  m_tdata,    // from_node, to_node, edge_weight
  output logic                                  m_tlast     // last_edge
);

  localparam int NB     = $clog2(MAX_NODES);
  localparam int CW     = $clog2(MAX_NODES + 1);
  localparam int SW     = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
  localparam int WDEPTH = 1 << (2 * NB);
  localparam int FB     = prim_mst_pkg::NODE_FIELD_BITS;
  localparam int WFB    = prim_mst_pkg::WEIGHT_FIELD_BITS;
  localparam int PADB   = prim_mst_pkg::M_DATA_BITS - 2 * FB - WFB;

  prim_mst_pkg::state_t state, state_next;

  logic [prim_mst_pkg::COUNT_BITS-1:0] node_count;
  logic [CW-1:0]        n;
  logic [CW-1:0]        step;
  logic [NB-1:0]        j;
  logic                 iss;
  logic                 p_valid;
  logic [NB-1:0]        p_idx;
  logic                 p_last;
  logic [SW-1:0]        best;
  logic [NB-1:0]        pick;
  logic                 found;
  logic [NB-1:0]        from;
  logic [MAX_NODES-1:0] in_tree;

  logic [FB-1:0]  in_row, in_col;
  logic [WFB-1:0] in_weight;
  logic [CW-1:0]  n_clamp;
  logic           in_go, run_start, wr_go;
  logic           j_last, step_last, loop_st, emit_go, lt, scan_take;

  logic [2*NB-1:0] w_raddr;
  logic [SW-1:0]   w_q, bd_q, bd_wdata, cmp_a, cmp_b;
  logic [NB-1:0]   near_q, near_wdata;
  logic            bd_we;

  assign in_row    = s_tdata[FB-1:0];
  assign in_col    = s_tdata[2*FB-1:FB];
  assign in_weight = s_tdata[2*FB+WFB-1:2*FB];

  assign n_clamp = (node_count > prim_mst_pkg::COUNT_BITS'(MAX_NODES)) ?
                   CW'(MAX_NODES) : CW'(node_count);

  assign s_tready  = (state == prim_mst_pkg::ST_IDLE);
  assign cfg_ready = (state == prim_mst_pkg::ST_IDLE);
  assign in_go     = s_tvalid && s_tready;
  assign run_start = in_go && (s_tuser == prim_mst_pkg::MODE_RUN) && (n_clamp >= CW'(2));
  assign wr_go     = in_go && (s_tuser == prim_mst_pkg::MODE_WRITE)
                     && ({1'b0, in_row} < (FB + 1)'(MAX_NODES))
                     && ({1'b0, in_col} < (FB + 1)'(MAX_NODES));

  assign j_last    = (CW'(j) == n - CW'(1));
  assign step_last = (step == n - CW'(1));
  assign loop_st   = (state == prim_mst_pkg::ST_INIT) || (state == prim_mst_pkg::ST_SCAN)
                     || (state == prim_mst_pkg::ST_UPDATE);
  assign emit_go   = !m_tvalid || m_tready;

  // The one comparator serves both the minimum search and the relaxation.
  assign lt = cmp_a < cmp_b;

  prim_mst_ram #(.DEPTH(WDEPTH), .WIDTH(SW)) u_weight_ram (
    .clk   (clk),
    .we    (wr_go),
    .waddr ({in_row[NB-1:0], in_col[NB-1:0]}),
    .wdata (SW'(in_weight)),
    .raddr (w_raddr),
    .rdata (w_q)
  );

  prim_mst_ram #(.DEPTH(MAX_NODES), .WIDTH(SW)) u_dist_ram (
    .clk   (clk),
    .we    (bd_we),
    .waddr (p_idx),
    .wdata (bd_wdata),
    .raddr (j),
    .rdata (bd_q)
  );

  prim_mst_ram #(.DEPTH(MAX_NODES), .WIDTH(NB)) u_near_ram (
    .clk   (clk),
    .we    (bd_we),
    .waddr (p_idx),
    .wdata (near_wdata),
    .raddr (pick),
    .rdata (near_q)
  );

  always_comb begin
    state_next = state;
    case (state)
      prim_mst_pkg::ST_IDLE: begin
        if (run_start) state_next = prim_mst_pkg::ST_INIT;
      end
      prim_mst_pkg::ST_INIT: begin
        if (p_valid && p_last) state_next = prim_mst_pkg::ST_SCAN;
      end
      prim_mst_pkg::ST_SCAN: begin
        if (p_valid && p_last) state_next = prim_mst_pkg::ST_FROM;
      end
      prim_mst_pkg::ST_FROM: state_next = prim_mst_pkg::ST_WGT;
      prim_mst_pkg::ST_WGT:  state_next = prim_mst_pkg::ST_EMIT;
      prim_mst_pkg::ST_EMIT: begin
        if (emit_go) begin
          state_next = step_last ? prim_mst_pkg::ST_IDLE : prim_mst_pkg::ST_UPDATE;
        end
      end
      prim_mst_pkg::ST_UPDATE: begin
        if (p_valid && p_last) state_next = prim_mst_pkg::ST_SCAN;
      end
      default: state_next = prim_mst_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    w_raddr    = {j, pick};
    cmp_a      = bd_q;
    cmp_b      = best;
    bd_we      = 1'b0;
    bd_wdata   = w_q;
    near_wdata = pick;
    scan_take  = 1'b0;
    case (state)
      prim_mst_pkg::ST_INIT: begin
        w_raddr    = {j, NB'(0)};
        bd_we      = p_valid;
        near_wdata = NB'(0);
      end
      prim_mst_pkg::ST_SCAN: begin
        scan_take = p_valid && !in_tree[p_idx] && (!found || lt);
      end
      prim_mst_pkg::ST_WGT: begin
        w_raddr = {near_q, pick};
      end
      prim_mst_pkg::ST_EMIT: begin
        w_raddr = {from, pick};
      end
      prim_mst_pkg::ST_UPDATE: begin
        cmp_a = w_q;
        cmp_b = bd_q;
        bd_we = p_valid && !in_tree[p_idx] && lt;
      end
      default: begin
        w_raddr = {j, pick};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= prim_mst_pkg::ST_IDLE;
      node_count <= prim_mst_pkg::COUNT_RESET;
      iss        <= 1'b0;
      p_valid    <= 1'b0;
      found      <= 1'b0;
      in_tree    <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        node_count <= cfg_data;
      end

      // Each pass issues one node address per cycle; the registered read data comes back
      // in the next cycle together with its index.
      p_valid <= loop_st && iss;
      p_idx   <= j;
      p_last  <= j_last;
      if (loop_st && iss) begin
        if (j_last) begin
          iss <= 1'b0;
        end else begin
          j <= j + NB'(1);
        end
      end
      if ((state_next != state) && ((state_next == prim_mst_pkg::ST_INIT)
          || (state_next == prim_mst_pkg::ST_SCAN) || (state_next == prim_mst_pkg::ST_UPDATE)))
      begin
        j   <= NB'(1);
        iss <= 1'b1;
      end

      if (run_start) begin
        n       <= n_clamp;
        step    <= CW'(1);
        in_tree <= MAX_NODES'(1);
      end

      if ((state != prim_mst_pkg::ST_SCAN) && (state_next == prim_mst_pkg::ST_SCAN)) begin
        found <= 1'b0;
      end
      if (scan_take) begin
        best  <= bd_q;
        pick  <= p_idx;
        found <= 1'b1;
      end

      if (state == prim_mst_pkg::ST_WGT) begin
        from <= near_q;
      end

      if ((state == prim_mst_pkg::ST_UPDATE) && p_valid && p_last) begin
        step <= step + CW'(1);
      end

      if ((state == prim_mst_pkg::ST_EMIT) && emit_go) begin
        in_tree[pick] <= 1'b1;
        m_tvalid      <= 1'b1;
        m_tdata       <= {PADB'(0), WFB'(w_q), FB'(pick), FB'(from)};
        m_tlast       <= step_last;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_root_in_tree: assert property (@(posedge clk) disable iff (rst)
    (state != prim_mst_pkg::ST_IDLE) |-> in_tree[0])
    else $error("node 0 left the tree during a run");

  a_scan_members: assert property (@(posedge clk) disable iff (rst)
    (state == prim_mst_pkg::ST_SCAN) |-> ($countones(in_tree) == int'(step)))
    else $error("tree size does not match the step count during the scan");

  a_update_members: assert property (@(posedge clk) disable iff (rst)
    (state == prim_mst_pkg::ST_UPDATE) |-> ($countones(in_tree) == int'(step) + 1))
    else $error("new node not marked before the relaxation pass");

  a_pick_valid: assert property (@(posedge clk) disable iff (rst)
    (state == prim_mst_pkg::ST_FROM) |-> (found && !in_tree[pick]))
    else $error("scan ended without a node outside the tree");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    ((state == prim_mst_pkg::ST_EMIT) && emit_go) |=> (m_tvalid && (m_tlast == $past(step_last))))
    else $error("edge not loaded into the output register");

endmodule

// File: design/prim_mst_ram.sv
// ----------------------------------------------------------------------------
// prim_mst_ram
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module prim_mst_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
